// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int RADDR_W  = 11;
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    localparam logic [CELL_W-1:0] GLYPH_CURSOR = 16'h0fb1;
    localparam logic [7:0]        ATTR_TEXT    = 8'h0f;
    localparam logic [CELL_W-1:0] CELL_BLANK   = 16'h0000;

    typedef enum logic [9:0] {
        ST_INIT   = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_PUT    = 10'b00_0000_0100,
        ST_TAB    = 10'b00_0000_1000,
        ST_GLYPH  = 10'b00_0001_0000,
        ST_COPY   = 10'b00_0010_0000,
        ST_ZROW   = 10'b00_0100_0000,
        ST_CLEAR  = 10'b00_1000_0000,
        ST_RDWAIT = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

endpackage

// ===== sv/tcw_if.sv =====
// Command and result channel interfaces.
interface tcw_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::OP_W-1:0]     opcode;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::RADDR_W-1:0]  read_address;

    modport source (output valid, opcode, char_code, read_address, input ready);
    modport sink   (input valid, opcode, char_code, read_address, output ready);
endinterface

interface tcw_res_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::CELL_W-1:0]   read_data;
    logic [tcw_pkg::CURSOR_W-1:0] cursor_position;

    modport source (output valid, read_data, cursor_position, input ready);
    modport sink   (input valid, read_data, cursor_position, output ready);
endinterface

// ===== sv/tcw_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/text_console_writer_top.sv =====
// Text console writer: cell store, cursor and command sequencer.
//
//  channel | dir | words                                    | handshake
//  cmd     | in  | opcode, char_code, read_address           | valid/ready
//  res     | out | read_data, cursor_position (one per cmd) | valid/ready
//
// Printable char, newline and backspace write one cell, then the cursor glyph; a tab
// writes its blanks one cell at a time; read fetches one cell; clear zeroes every cell.
// A scroll copies rows up and blanks the last row; all limited by the single RAM write port.
// After reset a zeroing sweep of all COLUMNS*ROWS cells runs with cmd.ready low.
// A finished result waits until the output register is free; no new command is taken meanwhile.
module text_console_writer_top #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    tcw_cmd_if.sink   cmd,
    tcw_res_if.source res
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int KEEP    = COLUMNS * (ROWS - 1);
    localparam int AW      = $clog2(CELLS);
    localparam int CW      = $clog2(CELLS + TAB_WIDTH);
    localparam int COLW    = $clog2(COLUMNS + 1);
    localparam int PW      = $clog2(TAB_WIDTH + 1);
    localparam int RAW     = (AW > tcw_pkg::RADDR_W) ? AW : tcw_pkg::RADDR_W;
    localparam int CXW     = (CW > tcw_pkg::CURSOR_W) ? CW : tcw_pkg::CURSOR_W;
    localparam int PH_LAST = (COLUMNS - 1) % TAB_WIDTH;

    tcw_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                   cursor_reg, cursor_next;
    logic [COLW-1:0]                 col_reg, col_next;
    logic [PW-1:0]                   phase_reg, phase_next;
    logic [PW-1:0]                   tab_left_reg, tab_left_next;
    logic [AW-1:0]                   sweep_reg, sweep_next;
    logic [tcw_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic                            rd_ok_reg, rd_ok_next;
    logic [tcw_pkg::CELL_W-1:0]      res_data_reg, res_data_next;
    logic                            out_valid_reg, out_valid_next;
    logic [tcw_pkg::CELL_W-1:0]      out_data_reg, out_data_next;
    logic [tcw_pkg::CURSOR_W-1:0]    out_cursor_reg, out_cursor_next;

    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]      mem_wdata;
    logic                            mem_re;
    logic [AW-1:0]                   mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]      mem_rdata;

    logic [RAW-1:0]                  raddr_ext;
    logic [CXW-1:0]                  cursor_ext;
    logic                            cur_in_range;
    logic [COLW-1:0]                 col_inc;
    logic [COLW-1:0]                 col_step;
    logic [PW-1:0]                   phase_step;
    logic                            out_free;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign raddr_ext    = RAW'(cmd.read_address);
    assign cursor_ext   = CXW'(cursor_reg);
    assign cur_in_range = (cursor_reg < CW'(CELLS));
    assign out_free     = !out_valid_reg || res.ready;
    assign col_inc      = col_reg + 1'b1;

    // one-cell advance of column and tab phase
    always_comb
    begin
        if (col_inc == COLW'(COLUMNS))
        begin
            col_step   = '0;
            phase_step = '0;
        end
        else
        begin
            col_step   = col_inc;
            phase_step = (phase_reg + 1'b1 == PW'(TAB_WIDTH)) ? '0 : phase_reg + 1'b1;
        end
    end

    assign cmd.ready           = (state_reg == tcw_pkg::ST_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.read_data       = out_data_reg;
    assign res.cursor_position = out_cursor_reg;

    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        phase_next      = phase_reg;
        tab_left_next   = tab_left_reg;
        sweep_next      = sweep_reg;
        char_next       = char_reg;
        rd_ok_next      = rd_ok_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_cursor_next = out_cursor_reg;
        mem_we          = 1'b0;
        mem_waddr       = cursor_reg[AW-1:0];
        mem_wdata       = tcw_pkg::CELL_BLANK;
        mem_re          = 1'b0;
        mem_raddr       = raddr_ext[AW-1:0];

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tcw_pkg::ST_INIT,
            tcw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    state_next = (state_reg == tcw_pkg::ST_INIT) ? tcw_pkg::ST_IDLE
                                                                 : tcw_pkg::ST_GLYPH;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            tcw_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    res_data_next = tcw_pkg::CELL_BLANK;
                    unique case (cmd.opcode)
                        tcw_pkg::OP_PUT:
                        begin
                            char_next  = cmd.char_code;
                            state_next = tcw_pkg::ST_PUT;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            cursor_next = '0;
                            col_next    = '0;
                            phase_next  = '0;
                            sweep_next  = '0;
                            state_next  = tcw_pkg::ST_CLEAR;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            mem_re     = 1'b1;
                            rd_ok_next = (raddr_ext < RAW'(CELLS));
                            state_next = tcw_pkg::ST_RDWAIT;
                        end
                        default:
                        begin
                            state_next = tcw_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            tcw_pkg::ST_PUT:
            begin
                priority if (char_reg == tcw_pkg::CH_LF || char_reg == tcw_pkg::CH_CR)
                begin
                    mem_we      = 1'b1;
                    cursor_next = cursor_reg + CW'(COLUMNS) - CW'(col_reg);
                    col_next    = '0;
                    phase_next  = '0;
                    state_next  = tcw_pkg::ST_GLYPH;
                end
                else if (char_reg == tcw_pkg::CH_TAB)
                begin
                    tab_left_next = PW'(TAB_WIDTH) - phase_reg;
                    state_next    = tcw_pkg::ST_TAB;
                end
                else if (char_reg == tcw_pkg::CH_BS)
                begin
                    mem_we = 1'b1;
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - 1'b1;
                        if (col_reg == '0)
                        begin
                            col_next   = COLW'(COLUMNS - 1);
                            phase_next = PW'(PH_LAST);
                        end
                        else
                        begin
                            col_next   = col_reg - 1'b1;
                            phase_next = (phase_reg == '0) ? PW'(TAB_WIDTH - 1)
                                                           : phase_reg - 1'b1;
                        end
                    end
                    state_next = tcw_pkg::ST_GLYPH;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = {tcw_pkg::ATTR_TEXT, char_reg};
                    cursor_next = cursor_reg + 1'b1;
                    col_next    = col_step;
                    phase_next  = phase_step;
                    state_next  = tcw_pkg::ST_GLYPH;
                end
            end

            tcw_pkg::ST_TAB:
            begin
                // blanks past the last cell are dropped
                mem_we        = cur_in_range;
                cursor_next   = cursor_reg + 1'b1;
                col_next      = col_step;
                phase_next    = phase_step;
                tab_left_next = tab_left_reg - 1'b1;
                if (tab_left_reg == PW'(1))
                begin
                    state_next = tcw_pkg::ST_GLYPH;
                end
            end

            tcw_pkg::ST_GLYPH:
            begin
                if (cur_in_range)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = tcw_pkg::GLYPH_CURSOR;
                    state_next = tcw_pkg::ST_DONE;
                end
                else
                begin
                    sweep_next = '0;
                    state_next = tcw_pkg::ST_COPY;
                end
            end

            tcw_pkg::ST_COPY:
            begin
                // read one row ahead, write the word read last cycle one row up
                mem_re    = (sweep_reg != AW'(KEEP));
                mem_raddr = sweep_reg + AW'(COLUMNS);
                mem_we    = (sweep_reg != '0);
                mem_waddr = sweep_reg - 1'b1;
                mem_wdata = mem_rdata;
                if (sweep_reg == AW'(KEEP))
                begin
                    state_next = tcw_pkg::ST_ZROW;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            tcw_pkg::ST_ZROW:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    cursor_next = CW'(KEEP);
                    col_next    = '0;
                    phase_next  = '0;
                    state_next  = tcw_pkg::ST_GLYPH;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            tcw_pkg::ST_RDWAIT:
            begin
                res_data_next = rd_ok_reg ? mem_rdata : tcw_pkg::CELL_BLANK;
                state_next    = tcw_pkg::ST_DONE;
            end

            tcw_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_cursor_next = cursor_ext[tcw_pkg::CURSOR_W-1:0];
                    state_next      = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            cursor_reg    <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tab_left_reg   <= tab_left_next;
        char_reg       <= char_next;
        rd_ok_reg      <= rd_ok_next;
        res_data_reg   <= res_data_next;
        out_data_reg   <= out_data_next;
        out_cursor_reg <= out_cursor_next;
    end

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [tcw_pkg::CELL_W-1:0]   res_read_data,
    input logic [tcw_pkg::CURSOR_W-1:0] res_cursor_position
);

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_read_data)
                                    && $stable(res_cursor_position))
        else $error("result word changed while stalled");

    // one command at a time: busy straight after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in progress");

    // the store is being zeroed when reset lifts
    a_init_sweep: assert property (@(posedge clk)
        $rose(rst_n) |-> !cmd_ready)
        else $error("command port open before zeroing sweep");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .res_read_data       (res.read_data),
    .res_cursor_position (res.cursor_position)
);
